/* rtl/core/gne_pkg.sv */
// Shared types and constants of the 3D gradient noise evaluator.
// No dependencies; gne_front, gne_interp and gradient_noise_3d_eval import this package.
package gne_pkg;

    localparam int TABLE_DEPTH = 514;
    localparam int ADDR_W      = 10;
    localparam int COORD_W     = 24;
    localparam int FRAC_W      = 16;
    localparam int CELL_W      = 8;
    localparam int DOT_W       = 34;
    localparam int PROD_W      = 52;

    localparam logic [7:0]  MASK_RESET = 8'hFF;
    localparam logic [17:0] FADE_K3    = 18'd196608;
    localparam logic signed [34:0] ROUND_HALF = 35'sd16384;
    localparam logic signed [34:0] SAT_MAX    = 35'sd32767;
    localparam logic signed [34:0] SAT_MIN    = -35'sd32768;

    localparam logic [1:0] OP_EVAL = 2'd0;
    localparam logic [1:0] OP_PERM = 2'd1;
    localparam logic [1:0] OP_GRAD = 2'd2;

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } t_grad;

    // Evaluate item leaving the table stages.
    typedef struct packed {
        logic             valid;
        logic [2:0][15:0] frac;
        logic [2:0][31:0] sq;
    } t_front;

endpackage

/* rtl/core/gne_item_if.sv */
// Input item channel of the noise evaluator.
// Depends on nothing.
interface gne_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [9:0]         table_index;
    logic [7:0]         perm_value;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;
    logic signed [15:0] grad_z;
    logic [23:0]        coord_x;
    logic [23:0]        coord_y;
    logic [23:0]        coord_z;
    logic [1:0]         channel_offset;

    modport source (output valid, operation, table_index, perm_value, grad_x, grad_y,
                    grad_z, coord_x, coord_y, coord_z, channel_offset, input ready);
    modport sink (input valid, operation, table_index, perm_value, grad_x, grad_y,
                  grad_z, coord_x, coord_y, coord_z, channel_offset, output ready);
endinterface

/* rtl/core/gne_noise_if.sv */
// Result item channel of the noise evaluator.
// Depends on nothing.
interface gne_noise_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] noise_value;

    modport source (output valid, noise_value, input ready);
    modport sink (input valid, noise_value, output ready);
endinterface

/* rtl/core/gne_cfg_if.sv */
// Configuration write channel carrying the lattice mask.
// Depends on nothing.
interface gne_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] lattice_mask;

    modport source (output valid, lattice_mask, input ready);
    modport sink (input valid, lattice_mask, output ready);
endinterface

/* rtl/core/gne_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gne_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

/* rtl/core/gne_front.sv */
// Table stages: lattice split, permutation hashing, gradient fetch and fraction squaring.
// Depends on gne_pkg, gne_item_if and gne_ram.
module gne_front import gne_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic [7:0]     i_mask,
    gne_item_if.sink       i_item,
    output t_front         o_front,
    output t_grad [7:0]    o_grad
);
    // Each table copy is written at the same stage where it is read, so reads and
    // writes of one copy happen in item order and need no forwarding.
    logic              w_acc;
    logic [CELL_W-1:0] w_c0 [3];
    logic [CELL_W-1:0] w_c1 [3];
    logic [7:0]        w_prd [6];
    logic [47:0]       w_grd [8];
    logic              w_we0, w_we1, w_we2;
    logic [ADDR_W-1:0] w_pa1 [4];
    logic [ADDR_W-1:0] w_base [4];
    logic [ADDR_W-1:0] w_ga [8];

    logic              r1_valid, r2_valid, r3_valid;
    logic [1:0]        r1_op, r2_op;
    logic [ADDR_W-1:0] r1_idx, r2_idx;
    logic [7:0]        r1_perm;
    t_grad             r1_grad, r2_grad;
    logic [CELL_W-1:0] r1_by0, r1_by1, r1_bz0, r1_bz1, r2_bz0, r2_bz1;
    logic [1:0]        r1_off, r2_off;
    logic [2:0][15:0]  r1_frac, r2_frac, r3_frac;
    logic [2:0][31:0]  r3_sq;

    assign w_acc = i_item.valid && i_en;

    always_comb begin
        w_c0[0] = i_item.coord_x[COORD_W-1:FRAC_W] & i_mask;
        w_c0[1] = i_item.coord_y[COORD_W-1:FRAC_W] & i_mask;
        w_c0[2] = i_item.coord_z[COORD_W-1:FRAC_W] & i_mask;
        for (int i = 0; i < 3; i++) begin
            w_c1[i] = (w_c0[i] + CELL_W'(1)) & i_mask;
        end
    end

    assign w_we0 = w_acc && i_item.operation == OP_PERM
                   && i_item.table_index < ADDR_W'(TABLE_DEPTH);
    assign w_we1 = i_en && r1_valid && r1_op == OP_PERM && r1_idx < ADDR_W'(TABLE_DEPTH);
    assign w_we2 = i_en && r2_valid && r2_op == OP_GRAD && r2_idx < ADDR_W'(TABLE_DEPTH);

    gne_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_perm_x0 (
        .i_clk, .i_we(w_we0), .i_waddr(i_item.table_index), .i_wdata(i_item.perm_value),
        .i_re(i_en), .i_raddr({2'b00, w_c0[0]}), .o_rdata(w_prd[0]));
    gne_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_perm_x1 (
        .i_clk, .i_we(w_we0), .i_waddr(i_item.table_index), .i_wdata(i_item.perm_value),
        .i_re(i_en), .i_raddr({2'b00, w_c1[0]}), .o_rdata(w_prd[1]));

    // Second-level hash addresses: x0/y0, x1/y0, x0/y1, x1/y1.
    always_comb begin
        w_pa1[0] = ADDR_W'(w_prd[0]) + ADDR_W'(r1_by0);
        w_pa1[1] = ADDR_W'(w_prd[1]) + ADDR_W'(r1_by0);
        w_pa1[2] = ADDR_W'(w_prd[0]) + ADDR_W'(r1_by1);
        w_pa1[3] = ADDR_W'(w_prd[1]) + ADDR_W'(r1_by1);
    end

    for (genvar g = 0; g < 4; g++) begin : g_perm_yz
        gne_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_perm (
            .i_clk, .i_we(w_we1), .i_waddr(r1_idx), .i_wdata(r1_perm),
            .i_re(i_en), .i_raddr(w_pa1[g]), .o_rdata(w_prd[g+2]));
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_base[i] = ADDR_W'(w_prd[i+2]) + ADDR_W'(r2_off);
        end
        // Corner k: bit 0 selects x1, bit 1 selects y1, bit 2 selects z1.
        for (int k = 0; k < 8; k++) begin
            w_ga[k] = w_base[k%4] + ADDR_W'((k >= 4) ? r2_bz1 : r2_bz0);
        end
    end

    for (genvar g = 0; g < 8; g++) begin : g_grad
        gne_ram #(.WIDTH(48), .DEPTH(TABLE_DEPTH)) u_grad (
            .i_clk, .i_we(w_we2), .i_waddr(r2_idx), .i_wdata(r2_grad),
            .i_re(i_en), .i_raddr(w_ga[g]), .o_rdata(w_grd[g]));
        assign o_grad[g] = t_grad'(w_grd[g]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= w_acc;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid && r2_op == OP_EVAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_op      <= i_item.operation;
            r1_idx     <= i_item.table_index;
            r1_perm    <= i_item.perm_value;
            r1_grad    <= '{z: i_item.grad_z, y: i_item.grad_y, x: i_item.grad_x};
            r1_by0     <= w_c0[1];
            r1_by1     <= w_c1[1];
            r1_bz0     <= w_c0[2];
            r1_bz1     <= w_c1[2];
            r1_off     <= i_item.channel_offset;
            r1_frac[0] <= i_item.coord_x[FRAC_W-1:0];
            r1_frac[1] <= i_item.coord_y[FRAC_W-1:0];
            r1_frac[2] <= i_item.coord_z[FRAC_W-1:0];
            r2_op      <= r1_op;
            r2_idx     <= r1_idx;
            r2_grad    <= r1_grad;
            r2_bz0     <= r1_bz0;
            r2_bz1     <= r1_bz1;
            r2_off     <= r1_off;
            r2_frac    <= r1_frac;
            r3_frac    <= r2_frac;
            for (int i = 0; i < 3; i++) begin
                r3_sq[i] <= r2_frac[i] * r2_frac[i];
            end
        end
    end

    assign o_front = '{valid: r3_valid, frac: r3_frac, sq: r3_sq};

`ifndef SYNTHESIS
    a_no_write_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |-> !(w_we0 || w_we1 || w_we2)) else $error("table write during stall");
    a_perm_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_valid && r1_op == OP_EVAL |-> w_pa1[3] < ADDR_W'(TABLE_DEPTH))
        else $error("hash address past table");
    a_grad_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_valid && r2_op == OP_EVAL |-> w_ga[7] < ADDR_W'(TABLE_DEPTH))
        else $error("gradient address past table");
`endif
endmodule

/* rtl/core/gne_interp.sv */
// Arithmetic stages: dot products, fade curves, trilinear blend, rounding and saturation.
// Depends on gne_pkg.
module gne_interp import gne_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_front             i_front,
    input  t_grad [7:0]        i_grad,
    output logic               o_valid,
    output logic signed [15:0] o_value
);
    logic signed [DOT_W-1:0]  n_dot [8];
    logic [15:0]              n_fade [3];
    logic signed [16:0]       w_rx, w_ry, w_rz;
    logic signed [34:0]       w_d4 [4], w_d6 [2], w_d8;
    logic signed [DOT_W-1:0]  w_v;
    logic signed [34:0]       w_r, w_q;

    logic                     r4_valid, r5_valid, r6_valid, r7_valid, r8_valid, r9_valid;
    logic                     r_out_valid;
    logic signed [DOT_W-1:0]  r4_dot [8];
    logic [15:0]              r4_s [3];
    logic [15:0]              r5_sy, r5_sz, r6_sy, r6_sz, r7_sz, r8_sz;
    logic signed [DOT_W-1:0]  r5_a [4], r6_l [4], r7_a [2], r8_l [2], r9_a;
    logic signed [PROD_W-1:0] r5_p [4], r7_p [2], r9_p;
    logic signed [15:0]       r_out_value;

    // The corner offset along an axis is f for the low corner and f - 1.0 for the high
    // corner; in 17-bit two's complement that is just the fraction with the top bit set.
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_rx = signed'({k[0], i_front.frac[0]});
            w_ry = signed'({k[1], i_front.frac[1]});
            w_rz = signed'({k[2], i_front.frac[2]});
            n_dot[k] = i_grad[k].x * w_rx + i_grad[k].y * w_ry + i_grad[k].z * w_rz;
        end
        for (int i = 0; i < 3; i++) begin
            n_fade[i] = 16'((50'(i_front.sq[i]) *
                             50'(FADE_K3 - {1'b0, i_front.frac[i], 1'b0})) >> 32);
        end
    end

    always_comb begin
        for (int p = 0; p < 4; p++) begin
            w_d4[p] = 35'(r4_dot[2*p+1]) - 35'(r4_dot[2*p]);
        end
        for (int p = 0; p < 2; p++) begin
            w_d6[p] = 35'(r6_l[2*p+1]) - 35'(r6_l[2*p]);
        end
        w_d8 = 35'(r8_l[1]) - 35'(r8_l[0]);
        w_v  = r9_a + DOT_W'(r9_p >>> 16);
        w_r  = 35'(w_v) + ROUND_HALF;
        w_q  = w_r >>> 15;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            r6_valid    <= 1'b0;
            r7_valid    <= 1'b0;
            r8_valid    <= 1'b0;
            r9_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid    <= i_front.valid;
            r5_valid    <= r4_valid;
            r6_valid    <= r5_valid;
            r7_valid    <= r6_valid;
            r8_valid    <= r7_valid;
            r9_valid    <= r8_valid;
            r_out_valid <= r9_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_dot <= n_dot;
            r4_s   <= n_fade;
            for (int p = 0; p < 4; p++) begin
                r5_a[p] <= r4_dot[2*p];
                r5_p[p] <= w_d4[p] * signed'({1'b0, r4_s[0]});
                r6_l[p] <= r5_a[p] + DOT_W'(r5_p[p] >>> 16);
            end
            r5_sy <= r4_s[1];
            r5_sz <= r4_s[2];
            r6_sy <= r5_sy;
            r6_sz <= r5_sz;
            for (int p = 0; p < 2; p++) begin
                r7_a[p] <= r6_l[2*p];
                r7_p[p] <= w_d6[p] * signed'({1'b0, r6_sy});
                r8_l[p] <= r7_a[p] + DOT_W'(r7_p[p] >>> 16);
            end
            r7_sz <= r6_sz;
            r8_sz <= r7_sz;
            r9_a  <= r8_l[0];
            r9_p  <= w_d8 * signed'({1'b0, r8_sz});
            if (w_q > SAT_MAX) begin
                r_out_value <= 16'sh7FFF;
            end else if (w_q < SAT_MIN) begin
                r_out_value <= -16'sh8000;
            end else begin
                r_out_value <= 16'(w_q);
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
endmodule

/* rtl/core/gradient_noise_3d_eval.sv */
// Channel  | Dir | Carries
// i_item   | in  | operation, table index, table data, coordinates, channel offset
// i_cfg    | in  | lattice mask register write
// o_noise  | out | signed Q1.15 noise value, one item per evaluate operation
//
// One item per cycle while the output is not stalled; an item passes r1 to r9 and
// the output register. The depth is set by two hash RAM reads, the gradient RAM
// read, the dot product and fade register, the three multiply-then-add lerp
// levels and the rounding register. All stages advance together and hold while
// the output register is full and not taken. Reset clears valids and sets the
// mask to 255; the tables are undefined until written.
// Depends on gne_pkg, the gne_*_if interfaces, gne_front and gne_interp.
module gradient_noise_3d_eval import gne_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gne_item_if.sink  i_item,
    gne_cfg_if.sink   i_cfg,
    gne_noise_if.source o_noise
);
    logic [7:0]   r_lattice_mask;
    logic         w_en;
    logic         w_out_valid;
    t_front       w_front;
    t_grad [7:0]  w_grad;

    assign w_en         = !w_out_valid || o_noise.ready;
    assign i_item.ready = w_en;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lattice_mask <= MASK_RESET;
        end else if (i_cfg.valid) begin
            r_lattice_mask <= i_cfg.lattice_mask;
        end
    end

    gne_front u_front (
        .i_clk, .i_rst_n, .i_en(w_en), .i_mask(r_lattice_mask),
        .i_item(i_item), .o_front(w_front), .o_grad(w_grad));

    gne_interp u_interp (
        .i_clk, .i_rst_n, .i_en(w_en), .i_front(w_front), .i_grad(w_grad),
        .o_valid(w_out_valid), .o_value(o_noise.noise_value));

    assign o_noise.valid = w_out_valid;
endmodule
